// File: rtl/est_pkg.sv
`default_nettype none
package est_pkg;

    localparam int ANGLE_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int ROT_W           = 34;

    typedef logic signed [15:0]      t_s16;
    typedef logic signed [31:0]      t_s32;
    typedef logic signed [ROT_W-1:0] t_rot;

    typedef struct packed {
        logic mode;
        t_s16 rot_x;
        t_s16 rot_y;
        t_s16 rot_z;
        t_s16 scale_x;
        t_s16 scale_y;
        t_s16 scale_z;
        t_s32 trans_x;
        t_s32 trans_y;
        t_s32 trans_z;
    } t_item;

    typedef struct packed {
        logic [1:0] column;
        t_s32       row0;
        t_s32       row1;
        t_s32       row2;
        logic       saturated;
        logic       last;
    } t_res;

    // rotation entries are indexed col*3+row
    typedef struct packed {
        logic           mode;
        t_rot [8:0]     rot;
        t_s16 [2:0]     scale;
        t_s32 [2:0]     trans;
    } t_job;

    typedef struct packed {
        logic sat;
        t_s32 val;
    } t_clamp;

    localparam logic [30:0] PI_HALF_Q30 = 31'd1686629713;
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [63:0] TWO32       = 64'd1 << 32;

    // Horner divisors: sine chain then cosine chain
    localparam logic [6:0] DIVISOR [9] = '{7'd72, 7'd42, 7'd20, 7'd6,
                                           7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
    localparam logic [31:0] RECIP [9] = '{32'(TWO32 / 72), 32'(TWO32 / 42),
                                          32'(TWO32 / 20), 32'(TWO32 / 6),
                                          32'(TWO32 / 90), 32'(TWO32 / 56),
                                          32'(TWO32 / 30), 32'(TWO32 / 12),
                                          32'(TWO32 / 2)};

    localparam logic signed [49:0] S32_MAX_W = 50'sd2147483647;
    localparam logic signed [49:0] S32_MIN_W = -50'sd2147483648;

    function automatic t_clamp clamp32(input logic signed [49:0] v);
        t_clamp res;
        res.sat = 1'b0;
        res.val = 32'(v);
        if (v > S32_MAX_W) begin
            res.sat = 1'b1;
            res.val = 32'sh7FFF_FFFF;
        end else if (v < S32_MIN_W) begin
            res.sat = 1'b1;
            res.val = 32'sh8000_0000;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// File: rtl/euler_scale_translate_matrix.sv
// Front end: takes one transform at a time, through its shared sine/cosine unit (three
// angles, one after another) and 14 serial products, then pushes it to the queue.
// Back end: model columns are scaled by multiplication and a translation column follows;
// normal columns divide by the scale in a 35-step divider and have no translation column.
// Reset: synchronous, active low; clears the queue and all control state.
`default_nettype none
module euler_scale_translate_matrix
    import est_pkg::*;
#(
    parameter int ANGLE_BITS  = ANGLE_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  push,
    output logic       full,
    input  wire t_item i_data,
    input  wire logic  pop,
    output logic       empty,
    output t_res       o_data
);

    localparam int JOB_W = $bits(t_job);

    logic             w_qpush;
    logic             w_qfull;
    logic             w_qpop;
    logic             w_qempty;
    t_job             w_job_in;
    logic [JOB_W-1:0] w_job_out;

    est_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_item  (i_data),
        .o_qpush (w_qpush),
        .i_qfull (w_qfull),
        .o_job   (w_job_in)
    );

    est_fifo #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_qpush),
        .o_full  (w_qfull),
        .i_data  (w_job_in),
        .i_pop   (w_qpop),
        .o_empty (w_qempty),
        .o_data  (w_job_out)
    );

    est_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qempty (w_qempty),
        .o_qpop   (w_qpop),
        .i_job    (t_job'(w_job_out)),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_res    (o_data)
    );

endmodule
`default_nettype wire

// File: rtl/est_sincos.sv
`default_nettype none
module est_sincos
    import est_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [15:0]        i_angle,
    output logic                    o_done,
    output logic signed [31:0]      o_sin,
    output logic signed [31:0]      o_cos
);

    typedef enum logic [3:0] {
        S_IDLE, S_MR, S_X, S_MXX, S_DIV, S_FIX, S_MUL, S_MXU, S_SIN, S_OUT
    } t_state;

    localparam logic [3:0] D_SIN_LAST = 4'd3;
    localparam logic [3:0] D_COS_LAST = 4'd8;

    t_state       r_state;
    logic [2:0]   r_oct;
    logic [29:0]  r_r;
    logic [29:0]  r_x;
    logic [29:0]  r_x2;
    logic [30:0]  r_acc;
    logic [30:0]  r_sin;
    logic [61:0]  r_prod;
    logic [29:0]  r_q0;
    logic [3:0]   r_d;

    logic [23:0]  w_a24;
    logic [23:0]  w_p;
    logic [55:0]  w_tw;
    logic [31:0]  w_t;
    logic [29:0]  w_r;
    logic [29:0]  w_n;
    logic [61:0]  w_dprod;
    logic [36:0]  w_qd;
    logic [36:0]  w_rem;
    logic [29:0]  w_q;
    logic [30:0]  w_acc_n;
    logic signed [31:0] w_sp;
    logic signed [31:0] w_cp;

    // angle taken to ANGLE_BITS, placed at the top of a 32-bit turn
    assign w_a24 = {i_angle, 8'd0};
    assign w_p   = w_a24 >> (24 - ANGLE_BITS);
    assign w_tw  = {32'd0, w_p} << (32 - ANGLE_BITS);
    assign w_t   = w_tw[31:0];
    assign w_r   = w_t[29] ? (30'h2000_0000 - {1'b0, w_t[28:0]}) : {1'b0, w_t[28:0]};

    // constant divide: reciprocal estimate, then one correction
    assign w_n     = r_prod[59:30];
    assign w_dprod = 62'(w_n) * 62'(RECIP[r_d]);
    assign w_qd    = 37'(r_q0) * 37'(DIVISOR[r_d]);
    assign w_rem   = 37'(w_n) - w_qd;
    assign w_q     = r_q0 + 30'(w_rem >= 37'(DIVISOR[r_d]));
    assign w_acc_n = Q30_ONE - 31'(w_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_d     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_oct   <= w_t[31:29];
                        r_r     <= w_r;
                        r_d     <= '0;
                        r_state <= S_MR;
                    end
                end
                S_MR: begin
                    r_prod  <= 62'(r_r) * 62'(PI_HALF_Q30);
                    r_state <= S_X;
                end
                S_X: begin
                    r_x     <= r_prod[59:30];
                    r_state <= S_MXX;
                end
                S_MXX: begin
                    r_prod  <= 62'(r_x) * 62'(r_x);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_d == 4'd0) begin
                        r_x2 <= w_n;
                    end
                    r_q0    <= w_dprod[61:32];
                    r_state <= S_FIX;
                end
                S_FIX: begin
                    r_acc <= w_acc_n;
                    if (r_d == D_SIN_LAST) begin
                        r_state <= S_MXU;
                    end else if (r_d == D_COS_LAST) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= 62'(r_x2) * 62'(r_acc);
                    r_d     <= r_d + 4'd1;
                    r_state <= S_DIV;
                end
                S_MXU: begin
                    r_prod  <= 62'(r_x) * 62'(r_acc);
                    r_state <= S_SIN;
                end
                S_SIN: begin
                    r_sin   <= r_prod[60:30];
                    r_d     <= r_d + 4'd1;
                    r_state <= S_MXX;
                end
                S_OUT: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // odd octants swap the series, the quadrant sets the signs
    assign w_sp = r_oct[0] ? $signed({1'b0, r_acc}) : $signed({1'b0, r_sin});
    assign w_cp = r_oct[0] ? $signed({1'b0, r_sin}) : $signed({1'b0, r_acc});

    always_comb begin
        case (r_oct[2:1])
            2'd0: begin
                o_sin = w_sp;
                o_cos = w_cp;
            end
            2'd1: begin
                o_sin = w_cp;
                o_cos = -w_sp;
            end
            2'd2: begin
                o_sin = -w_sp;
                o_cos = -w_cp;
            end
            default: begin
                o_sin = -w_cp;
                o_cos = w_sp;
            end
        endcase
    end

    assign o_done = (r_state == S_OUT);

endmodule
`default_nettype wire

// File: rtl/est_front.sv
`default_nettype none
module est_front
    import est_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    output logic       o_full,
    input  wire t_item i_item,
    output logic       o_qpush,
    input  wire logic  i_qfull,
    output t_job       o_job
);

    typedef enum logic [2:0] {F_IDLE, F_ANG, F_MUL, F_TAIL, F_PUSH} t_state;

    localparam logic [3:0] OP_LAST = 4'd13;

    t_state             r_state;
    t_item              r_item;
    logic               r_start;
    logic [1:0]         r_k;
    logic signed [31:0] r_sv [3];
    logic signed [31:0] r_cv [3];
    logic [3:0]         r_op;
    logic               r_pv;
    logic [3:0]         r_pidx;
    logic signed [63:0] r_mprod;
    logic signed [31:0] r_m [14];

    logic [15:0]        w_angle;
    logic               w_done;
    logic signed [31:0] w_sin;
    logic signed [31:0] w_cos;
    logic signed [31:0] w_opa;
    logic signed [31:0] w_opb;
    logic               w_neg;
    logic [63:0]        w_mag;
    logic [63:0]        w_rmag;
    logic signed [31:0] w_mres;

    // angle order: yaw, pitch, roll
    always_comb begin
        case (r_k)
            2'd0:    w_angle = r_item.rot_y;
            2'd1:    w_angle = r_item.rot_x;
            default: w_angle = r_item.rot_z;
        endcase
    end

    est_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sincos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_angle (w_angle),
        .o_done  (w_done),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    // product schedule; P = S1*S2 lands in m0, Q = C1*S2 in m1
    always_comb begin
        case (r_op)
            4'd0:    begin w_opa = r_sv[0]; w_opb = r_sv[1]; end
            4'd1:    begin w_opa = r_cv[0]; w_opb = r_sv[1]; end
            4'd2:    begin w_opa = r_cv[0]; w_opb = r_cv[2]; end
            4'd3:    begin w_opa = r_m[0];  w_opb = r_sv[2]; end
            4'd4:    begin w_opa = r_cv[1]; w_opb = r_sv[2]; end
            4'd5:    begin w_opa = r_m[1];  w_opb = r_sv[2]; end
            4'd6:    begin w_opa = r_cv[2]; w_opb = r_sv[0]; end
            4'd7:    begin w_opa = r_m[0];  w_opb = r_cv[2]; end
            4'd8:    begin w_opa = r_cv[0]; w_opb = r_sv[2]; end
            4'd9:    begin w_opa = r_cv[1]; w_opb = r_cv[2]; end
            4'd10:   begin w_opa = r_m[1];  w_opb = r_cv[2]; end
            4'd11:   begin w_opa = r_sv[0]; w_opb = r_sv[2]; end
            4'd12:   begin w_opa = r_cv[1]; w_opb = r_sv[0]; end
            4'd13:   begin w_opa = r_cv[0]; w_opb = r_cv[1]; end
            default: begin w_opa = '0;      w_opb = '0;      end
        endcase
    end

    // Q30 product, rounded half away from zero
    assign w_neg  = r_mprod[63];
    assign w_mag  = w_neg ? 64'(-r_mprod) : 64'(r_mprod);
    assign w_rmag = (w_mag + (64'd1 << 29)) >> 30;
    assign w_mres = w_neg ? -$signed(32'(w_rmag)) : $signed(32'(w_rmag));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_start <= 1'b0;
            r_pv    <= 1'b0;
            r_k     <= '0;
            r_op    <= '0;
        end else begin
            if (r_pv) begin
                r_m[r_pidx] <= w_mres;
            end
            case (r_state)
                F_IDLE: begin
                    r_start <= i_push;
                    if (i_push) begin
                        r_item  <= i_item;
                        r_k     <= '0;
                        r_state <= F_ANG;
                    end
                end
                F_ANG: begin
                    r_start <= w_done && (r_k != 2'd2);
                    if (w_done) begin
                        r_sv[r_k] <= w_sin;
                        r_cv[r_k] <= w_cos;
                        if (r_k == 2'd2) begin
                            r_op    <= '0;
                            r_state <= F_MUL;
                        end else begin
                            r_k     <= r_k + 2'd1;
                        end
                    end
                end
                F_MUL: begin
                    r_mprod <= 64'(w_opa) * 64'(w_opb);
                    r_pv    <= 1'b1;
                    r_pidx  <= r_op;
                    if (r_op == OP_LAST) begin
                        r_state <= F_TAIL;
                    end else begin
                        r_op <= r_op + 4'd1;
                    end
                end
                F_TAIL: begin
                    r_pv    <= 1'b0;
                    r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_qfull) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

    assign o_full  = (r_state != F_IDLE);
    assign o_qpush = (r_state == F_PUSH);

    always_comb begin
        o_job.mode     = r_item.mode;
        o_job.rot[0]   = t_rot'(r_m[2]) + t_rot'(r_m[3]);
        o_job.rot[1]   = t_rot'(r_m[4]);
        o_job.rot[2]   = t_rot'(r_m[5]) - t_rot'(r_m[6]);
        o_job.rot[3]   = t_rot'(r_m[7]) - t_rot'(r_m[8]);
        o_job.rot[4]   = t_rot'(r_m[9]);
        o_job.rot[5]   = t_rot'(r_m[10]) + t_rot'(r_m[11]);
        o_job.rot[6]   = t_rot'(r_m[12]);
        o_job.rot[7]   = -t_rot'(r_sv[1]);
        o_job.rot[8]   = t_rot'(r_m[13]);
        o_job.scale[0] = r_item.scale_x;
        o_job.scale[1] = r_item.scale_y;
        o_job.scale[2] = r_item.scale_z;
        o_job.trans[0] = r_item.trans_x;
        o_job.trans[1] = r_item.trans_y;
        o_job.trans[2] = r_item.trans_z;
    end

endmodule
`default_nettype wire

// File: rtl/est_fifo.sv
`default_nettype none
module est_fifo
    import est_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    output logic                  o_full,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic [WIDTH-1:0]      o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic             w_wen;
    logic             w_ren;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wen   = i_push && !o_full;
    assign w_ren   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wen) begin
                r_mem[r_wr] <= i_data;
                r_wr        <= (r_wr == PTR_LAST) ? '0 : r_wr + PW'(1);
            end
            if (w_ren) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PW'(1);
            end
            if (w_wen && !w_ren) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_ren && !w_wen) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/est_back.sv
`default_nettype none
module est_back
    import est_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_qempty,
    output logic      o_qpop,
    input  wire t_job i_job,
    output logic      o_empty,
    input  wire logic i_pop,
    output t_res      o_res
);

    typedef enum logic [2:0] {B_IDLE, B_ROW, B_MRND, B_DIV, B_DRND, B_EMIT} t_state;

    localparam logic [1:0] COL_TRANS = 2'd3;
    localparam logic [5:0] DIV_STEPS = 6'd34;

    t_state             r_state;
    t_job               r_job;
    logic [1:0]         r_col;
    logic [1:0]         r_row;
    logic signed [31:0] r_ent [3];
    logic               r_sat;
    logic signed [49:0] r_mprod;
    logic [22:0]        r_rem;
    logic [34:0]        r_quo;
    logic [5:0]         r_cnt;
    logic               r_neg;
    t_res               r_out;
    logic               r_ovalid;

    logic [3:0]         w_ridx;
    logic [1:0]         w_sidx;
    t_rot               w_rv;
    t_s16               w_sc;
    logic [32:0]        w_absr;
    logic [21:0]        w_absd;
    logic [34:0]        w_num;
    logic [23:0]        w_den;
    logic [23:0]        w_rsh;
    logic               w_ge;
    logic               w_mneg;
    logic [49:0]        w_mmag;
    logic [49:0]        w_mrnd;
    t_clamp             w_mcl;
    t_clamp             w_dcl;
    t_s32               w_zero;
    logic               w_last;

    assign w_ridx = 4'({2'b0, r_col} * 4'd3 + {2'b0, r_row});
    assign w_sidx = (r_col == COL_TRANS) ? 2'd0 : r_col;
    assign w_rv   = r_job.rot[w_ridx];
    assign w_sc   = r_job.scale[w_sidx];
    assign w_absr = w_rv[ROT_W-1] ? 33'(-w_rv) : 33'(w_rv);
    assign w_absd = {(w_sc[15] ? 16'(-w_sc) : 16'(w_sc)), 6'd0};
    // round to nearest: (2|R| + |d|) / (2|d|)
    assign w_num  = {1'b0, w_absr, 1'b0} + 35'(w_absd);
    assign w_den  = {1'b0, w_absd, 1'b0};
    assign w_rsh  = {r_rem, r_quo[34]};
    assign w_ge   = (w_rsh >= w_den);

    assign w_mneg = r_mprod[49];
    assign w_mmag = w_mneg ? 50'(-r_mprod) : 50'(r_mprod);
    assign w_mrnd = (w_mmag + (50'd1 << 21)) >> 22;
    assign w_mcl  = clamp32(w_mneg ? -$signed(w_mrnd) : $signed(w_mrnd));
    assign w_dcl  = clamp32(r_neg ? -$signed(50'(r_quo)) : $signed(50'(r_quo)));

    always_comb begin
        if (w_rv > 0) begin
            w_zero = 32'sh7FFF_FFFF;
        end else if (w_rv < 0) begin
            w_zero = 32'sh8000_0000;
        end else begin
            w_zero = '0;
        end
    end

    assign w_last = r_job.mode ? (r_col == 2'd2) : (r_col == COL_TRANS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
            r_col    <= '0;
            r_row    <= '0;
            r_sat    <= 1'b0;
            r_cnt    <= '0;
        end else begin
            // in B_EMIT a popped beat is always replaced below
            if (i_pop && r_ovalid && (r_state != B_EMIT)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (!i_qempty) begin
                        r_job   <= i_job;
                        r_col   <= '0;
                        r_row   <= '0;
                        r_sat   <= 1'b0;
                        r_state <= B_ROW;
                    end
                end
                B_ROW: begin
                    if (r_col == COL_TRANS) begin
                        r_ent[0] <= r_job.trans[0];
                        r_ent[1] <= r_job.trans[1];
                        r_ent[2] <= r_job.trans[2];
                        r_state  <= B_EMIT;
                    end else if (!r_job.mode) begin
                        r_mprod <= 50'(w_sc) * 50'(w_rv);
                        r_state <= B_MRND;
                    end else if (w_sc == 0) begin
                        r_ent[r_row] <= w_zero;
                        r_sat        <= 1'b1;
                        if (r_row == 2'd2) begin
                            r_state <= B_EMIT;
                        end else begin
                            r_row <= r_row + 2'd1;
                        end
                    end else begin
                        r_rem   <= '0;
                        r_quo   <= w_num;
                        r_cnt   <= DIV_STEPS;
                        r_neg   <= w_rv[ROT_W-1] ^ w_sc[15];
                        r_state <= B_DIV;
                    end
                end
                B_MRND: begin
                    r_ent[r_row] <= w_mcl.val;
                    r_sat        <= r_sat | w_mcl.sat;
                    if (r_row == 2'd2) begin
                        r_state <= B_EMIT;
                    end else begin
                        r_row   <= r_row + 2'd1;
                        r_state <= B_ROW;
                    end
                end
                B_DIV: begin
                    r_rem <= w_ge ? 23'(w_rsh - w_den) : 23'(w_rsh);
                    r_quo <= {r_quo[33:0], w_ge};
                    if (r_cnt == 6'd0) begin
                        r_state <= B_DRND;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                B_DRND: begin
                    r_ent[r_row] <= w_dcl.val;
                    r_sat        <= r_sat | w_dcl.sat;
                    if (r_row == 2'd2) begin
                        r_state <= B_EMIT;
                    end else begin
                        r_row   <= r_row + 2'd1;
                        r_state <= B_ROW;
                    end
                end
                B_EMIT: begin
                    if (!r_ovalid || i_pop) begin
                        r_ovalid        <= 1'b1;
                        r_out.column    <= r_col;
                        r_out.row0      <= r_ent[0];
                        r_out.row1      <= r_ent[1];
                        r_out.row2      <= r_ent[2];
                        r_out.saturated <= r_sat;
                        r_out.last      <= w_last;
                        r_sat           <= 1'b0;
                        r_row           <= '0;
                        r_col           <= r_col + 2'd1;
                        r_state         <= w_last ? B_IDLE : B_ROW;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    assign o_qpop  = (r_state == B_IDLE) && !i_qempty;
    assign o_empty = !r_ovalid;
    assign o_res   = r_out;

endmodule
`default_nettype wire
